@@ hdl/acfe_pkg.sv @@
// Shared types, codes and sizes of the climate frame encoder.
package acfe_pkg;

   localparam int FRAME_BITS   = 52;
   localparam int TEMP_W       = 6;
   localparam int T16_W        = 10;
   localparam int MARK_W       = 12;
   localparam int SPACE_W      = 14;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 14;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int PULSE_W      = 6;

   localparam logic [PULSE_W-1:0] PULSE_HEADER = PULSE_W'(0);
   localparam logic [PULSE_W-1:0] PULSE_FOOTER = PULSE_W'(FRAME_BITS + 1);
   localparam logic [PULSE_W-1:0] PULSE_FINAL  = PULSE_W'(FRAME_BITS + 2);

   typedef enum logic [1:0] {
      MODE_OFF  = 2'd0,
      MODE_HEAT = 2'd1,
      MODE_DRY  = 2'd2,
      MODE_COOL = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      FAN_LOW   = 2'd0,
      FAN_MED   = 2'd1,
      FAN_HIGH  = 2'd2,
      FAN_QUIET = 2'd3
   } fan_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TEMP_MIN      = 3'd0,
      CSR_TEMP_MAX      = 3'd1,
      CSR_COOL_TEMP_MIN = 3'd2,
      CSR_BIT_MARK      = 3'd3,
      CSR_HEADER_SPACE  = 3'd4,
      CSR_ONE_SPACE     = 3'd5,
      CSR_ZERO_SPACE    = 3'd6
   } csr_index_type;

   localparam logic [7:0] CODE_COOL_LOW  = 8'h22;
   localparam logic [7:0] CODE_COOL_MED  = 8'h11;
   localparam logic [7:0] CODE_COOL_HIGH = 8'h08;
   localparam logic [7:0] CODE_HEAT_HIGH = 8'h03;
   localparam logic [7:0] CODE_DRY_LOW   = 8'h24;
   localparam logic [3:0] POWER_ON_CODE  = 4'h3;
   localparam logic [3:0] POWER_OFF_CODE = 4'h0;
   localparam logic [2:0] SWING_OFF_CODE = 3'h2;
   localparam logic [2:0] SWING_ON_CODE  = 3'h4;
   localparam logic [3:0] CHECK_BASE     = 4'hF;

   localparam logic [TEMP_W-1:0]  RST_TEMP_MIN      = 6'd16;
   localparam logic [TEMP_W-1:0]  RST_TEMP_MAX      = 6'd31;
   localparam logic [TEMP_W-1:0]  RST_COOL_TEMP_MIN = 6'd18;
   localparam logic [MARK_W-1:0]  RST_BIT_MARK      = 12'd511;
   localparam logic [SPACE_W-1:0] RST_HEADER_SPACE  = 14'd3492;
   localparam logic [SPACE_W-1:0] RST_ONE_SPACE     = 14'd1540;
   localparam logic [SPACE_W-1:0] RST_ZERO_SPACE    = 14'd548;

   typedef struct packed {
      logic [TEMP_W-1:0]  temp_min;
      logic [TEMP_W-1:0]  temp_max;
      logic [TEMP_W-1:0]  cool_temp_min;
      logic [MARK_W-1:0]  bit_mark_time;
      logic [SPACE_W-1:0] header_space_time;
      logic [SPACE_W-1:0] one_space_time;
      logic [SPACE_W-1:0] zero_space_time;
   } cfg_type;

   typedef struct packed {
      logic [FRAME_BITS-1:0] frame;
      logic [TEMP_W-1:0]     temp;
      logic [1:0]            fan;
   } entry_type;

   typedef struct packed {
      logic valid;
      logic ready;
   } hs_type;

endpackage

@@ hdl/acfe_if.sv @@
// Channel interfaces: request, pulse response and register write.
interface acfe_req_if;
   import acfe_pkg::*;
   logic             valid;
   logic             ready;
   logic [1:0]       climate_mode;
   logic [1:0]       fan_speed;
   logic             swing_on;
   logic [T16_W-1:0] target_temp;
   modport source (output valid, climate_mode, fan_speed, swing_on, target_temp,
                   input ready);
   modport sink   (input valid, climate_mode, fan_speed, swing_on, target_temp,
                   output ready);
endinterface

interface acfe_rsp_if;
   import acfe_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [MARK_W-1:0]     mark_time;
   logic [SPACE_W-1:0]    space_time;
   logic                  last_pulse;
   logic [FRAME_BITS-1:0] frame_code;
   logic [TEMP_W-1:0]     applied_temp;
   logic [1:0]            applied_fan;
   modport source (output valid, mark_time, space_time, last_pulse, frame_code,
                   applied_temp, applied_fan, input ready);
   modport sink   (input valid, mark_time, space_time, last_pulse, frame_code,
                   applied_temp, applied_fan, output ready);
endinterface

interface acfe_csr_if;
   import acfe_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  reg_index;
   logic [CSR_DATA_W-1:0] wdata;
   modport source (output valid, reg_index, wdata, input ready);
   modport sink   (input valid, reg_index, wdata, output ready);
endinterface

@@ hdl/ac_ir_frame_encoder_top.sv @@
// Top level of the climate remote frame encoder.
//
// req_chan takes one climate request per transaction (mode, fan, swing,
// target temperature in sixteenths of a degree). rsp_chan returns 55 pulse
// transactions for it: header, 52 frame bits MSB first, footer, and a final
// mark with last_pulse set. Every pulse carries the frame, the applied
// temperature and the applied fan. csr_chan writes the seven timing and
// limit registers; it is always ready and takes effect on the next cycle.
// A request is registered in the request stage, pushed into the queue and
// popped by the sequencer, whose output register holds its first pulse. The
// sequencer sends one pulse per cycle, paced by its pulse counter, while
// rsp_chan is ready. A two-entry queue after the request stage keeps
// accepting requests while pulses of an earlier frame are still going out.
// Reset clears all handshake state and loads the register defaults. When
// the receiver stalls, the current pulse holds on rsp_chan, the sequencer
// waits, and req_chan drops ready once the queue and request stage are full.
module ac_ir_frame_encoder_top (
   input  logic       clock,
   input  logic       reset,
   acfe_req_if.sink   req_chan,
   acfe_rsp_if.source rsp_chan,
   acfe_csr_if.sink   csr_chan
);
   import acfe_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   hs_type    push_hs;
   logic      push_ready;
   entry_type push_entry;
   logic      pop_valid, pop_ready;
   entry_type pop_entry;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         case (csr_chan.reg_index)
            CSR_TEMP_MIN:      cfg_in.temp_min          = csr_chan.wdata[TEMP_W-1:0];
            CSR_TEMP_MAX:      cfg_in.temp_max          = csr_chan.wdata[TEMP_W-1:0];
            CSR_COOL_TEMP_MIN: cfg_in.cool_temp_min     = csr_chan.wdata[TEMP_W-1:0];
            CSR_BIT_MARK:      cfg_in.bit_mark_time     = csr_chan.wdata[MARK_W-1:0];
            CSR_HEADER_SPACE:  cfg_in.header_space_time = csr_chan.wdata[SPACE_W-1:0];
            CSR_ONE_SPACE:     cfg_in.one_space_time    = csr_chan.wdata[SPACE_W-1:0];
            CSR_ZERO_SPACE:    cfg_in.zero_space_time   = csr_chan.wdata[SPACE_W-1:0];
            default:           ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.temp_min          <= RST_TEMP_MIN;
         cfg_ff.temp_max          <= RST_TEMP_MAX;
         cfg_ff.cool_temp_min     <= RST_COOL_TEMP_MIN;
         cfg_ff.bit_mark_time     <= RST_BIT_MARK;
         cfg_ff.header_space_time <= RST_HEADER_SPACE;
         cfg_ff.one_space_time    <= RST_ONE_SPACE;
         cfg_ff.zero_space_time   <= RST_ZERO_SPACE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   acfe_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .cfg         (cfg_ff),
      .push_hs_out (push_hs),
      .push_ready  (push_ready),
      .push_entry  (push_entry)
   );

   acfe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_hs    (push_hs),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   acfe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_entry (pop_entry),
      .rsp_chan  (rsp_chan)
   );

endmodule

@@ hdl/acfe_front.sv @@
// Request stage: register a transaction, map codes, clamp temperature, pack frame.
module acfe_front (
   input  logic                clock,
   input  logic                reset,
   acfe_req_if.sink            req_chan,
   input  acfe_pkg::cfg_type   cfg,
   output acfe_pkg::hs_type    push_hs_out,
   input  logic                push_ready,
   output acfe_pkg::entry_type push_entry
);
   import acfe_pkg::*;

   logic             s_valid_ff, s_valid_in;
   mode_type         mode_ff;
   fan_type          fan_ff;
   logic             swing_ff;
   logic [T16_W-1:0] t16_ff;

   logic [3:0]        power;
   logic [7:0]        mf_code;
   logic              quiet;
   logic [1:0]        applied_fan;
   logic [T16_W-1:0]  lo16, hi16, t16c;
   logic [T16_W:0]    rnd;
   logic [TEMP_W-1:0] temp;
   logic [TEMP_W+3:0] div_prod;
   logic [3:0]        t1, t2, nib4, sum, chk;
   logic [2:0]        swing_code;
   logic              accept, push;

   assign push           = s_valid_ff & push_ready;
   assign req_chan.ready = ~s_valid_ff | push_ready;
   assign accept         = req_chan.valid & req_chan.ready;
   assign push_hs_out    = '{valid: s_valid_ff, ready: push_ready};

   always_comb begin
      s_valid_in = s_valid_ff;
      if (accept) begin
         s_valid_in = 1'b1;
      end else if (push) begin
         s_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
      end else begin
         s_valid_ff <= s_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff  <= mode_type'(req_chan.climate_mode);
         fan_ff   <= fan_type'(req_chan.fan_speed);
         swing_ff <= req_chan.swing_on;
         t16_ff   <= req_chan.target_temp;
      end
   end

   always_comb begin
      power       = POWER_ON_CODE;
      mf_code     = CODE_COOL_LOW;
      quiet       = 1'b0;
      applied_fan = fan_ff;
      unique case (mode_ff)
         MODE_OFF: begin
            power = POWER_OFF_CODE;
         end
         MODE_HEAT: begin
            unique case (fan_ff)
               FAN_HIGH:  mf_code = CODE_HEAT_HIGH;
               FAN_MED:   applied_fan = FAN_LOW;
               FAN_QUIET: quiet = 1'b1;
               default:   ;
            endcase
         end
         MODE_DRY: begin
            mf_code = CODE_DRY_LOW;
         end
         MODE_COOL: begin
            unique case (fan_ff)
               FAN_HIGH:  mf_code = CODE_COOL_HIGH;
               FAN_MED:   mf_code = CODE_COOL_MED;
               FAN_QUIET: quiet = 1'b1;
               default:   ;
            endcase
         end
         default: ;
      endcase
   end

   always_comb begin
      lo16 = {(mode_ff == MODE_COOL) ? cfg.cool_temp_min : cfg.temp_min, 4'b0000};
      hi16 = {cfg.temp_max, 4'b0000};
      if (t16_ff < lo16) begin
         t16c = lo16;
      end else if (t16_ff > hi16) begin
         t16c = hi16;
      end else begin
         t16c = t16_ff;
      end
      rnd        = {1'b0, t16c} + (T16_W+1)'(8);
      temp       = rnd[TEMP_W+3:4];
      div_prod   = {4'b0000, temp} * (TEMP_W+4)'(13);
      t1         = {1'b0, div_prod[TEMP_W+3:TEMP_W+1]};
      t2         = temp[3:0] - cfg.temp_min[3:0];
      swing_code = swing_ff ? SWING_ON_CODE : SWING_OFF_CODE;
      nib4       = {quiet, swing_code};
      sum        = t2 + mf_code[3:0] + mf_code[7:4] + nib4 + t1 + power;
      chk        = CHECK_BASE - sum;
   end

   always_comb begin
      push_entry.frame        = '0;
      push_entry.frame[3:0]   = chk;
      push_entry.frame[7:4]   = t2;
      push_entry.frame[15:8]  = mf_code;
      push_entry.frame[19:16] = nib4;
      push_entry.frame[23:20] = t1;
      push_entry.frame[47:44] = power;
      push_entry.temp         = temp;
      push_entry.fan          = applied_fan;
   end

endmodule

@@ hdl/acfe_queue.sv @@
// Short queue of packed frames between request stage and pulse sequencer.
module acfe_queue (
   input  logic                clock,
   input  logic                reset,
   input  acfe_pkg::hs_type    push_hs,
   input  acfe_pkg::entry_type push_entry,
   output logic                push_ready,
   output logic                pop_valid,
   input  logic                pop_ready,
   output acfe_pkg::entry_type pop_entry
);
   import acfe_pkg::*;

   entry_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              push, pop;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign push       = push_hs.valid & push_hs.ready;
   assign pop        = pop_valid & pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push & ~pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop & ~push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ hdl/acfe_back.sv @@
// Pulse sequencer: header, frame bits MSB first, footer, final mark.
module acfe_back (
   input  logic                clock,
   input  logic                reset,
   input  acfe_pkg::cfg_type   cfg,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  acfe_pkg::entry_type pop_entry,
   acfe_rsp_if.source          rsp_chan
);
   import acfe_pkg::*;

   logic                  busy_ff, busy_in;
   logic [PULSE_W-1:0]    idx_ff, idx_in;
   entry_type             cur_ff;
   logic [FRAME_BITS-1:0] shift_ff, shift_in;

   logic                  out_valid_ff, out_valid_in;
   logic [MARK_W-1:0]     mark_ff;
   logic [SPACE_W-1:0]    space_ff, space_in;
   logic                  last_ff, last_in;
   entry_type             out_ent_ff;

   logic advance, emit, at_final, pop;

   assign advance   = ~out_valid_ff | rsp_chan.ready;
   assign emit      = busy_ff & advance;
   assign at_final  = (idx_ff == PULSE_FINAL);
   assign pop_ready = ~busy_ff | (emit & at_final);
   assign pop       = pop_valid & pop_ready;

   always_comb begin
      space_in = cfg.header_space_time;
      last_in  = 1'b0;
      shift_in = shift_ff;
      if (idx_ff == PULSE_HEADER || idx_ff == PULSE_FOOTER) begin
         space_in = cfg.header_space_time;
      end else if (at_final) begin
         space_in = '0;
         last_in  = 1'b1;
      end else begin
         space_in = shift_ff[FRAME_BITS-1] ? cfg.one_space_time : cfg.zero_space_time;
         shift_in = {shift_ff[FRAME_BITS-2:0], 1'b0};
      end
   end

   always_comb begin
      busy_in      = busy_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         idx_in       = at_final ? PULSE_HEADER : idx_ff + 1'b1;
      end else if (advance) begin
         out_valid_in = 1'b0;
      end
      if (pop) begin
         busy_in = 1'b1;
      end else if (emit & at_final) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= PULSE_HEADER;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff   <= pop_entry;
         shift_ff <= pop_entry.frame;
      end else if (emit) begin
         shift_ff <= shift_in;
      end
      if (emit) begin
         mark_ff    <= cfg.bit_mark_time;
         space_ff   <= space_in;
         last_ff    <= last_in;
         out_ent_ff <= cur_ff;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.mark_time    = mark_ff;
   assign rsp_chan.space_time   = space_ff;
   assign rsp_chan.last_pulse   = last_ff;
   assign rsp_chan.frame_code   = out_ent_ff.frame;
   assign rsp_chan.applied_temp = out_ent_ff.temp;
   assign rsp_chan.applied_fan  = out_ent_ff.fan;

endmodule
